// File: sv/assert_macros.svh
// Assertion helper macros for the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: sv/nss_pkg.sv
// ----------------------------------------------------------------------------
// nss_pkg
// Shared constants and types for the note sample selector.
// ----------------------------------------------------------------------------
`default_nettype none
package nss_pkg;
    localparam int MAX_ZONES    = 32;
    localparam int MAX_VARIANTS = 8;
    localparam int MAX_RECORDS  = 512;

    localparam logic [31:0] LCG_MUL = 32'd1664525;
    localparam logic [31:0] LCG_ADD = 32'd1013904223;

    localparam logic [1:0] MODE_HDR  = 2'd0;
    localparam logic [1:0] MODE_REC  = 2'd1;
    localparam logic [1:0] MODE_PICK = 2'd2;

    localparam logic [1:0] CFG_THRESH = 2'd0;
    localparam logic [1:0] CFG_ZCOUNT = 2'd1;
    localparam logic [1:0] CFG_SEED   = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [8:0]  note;
        logic [16:0] velocity;
        logic [4:0]  zone_index;
        logic        layer;
        logic [2:0]  slot;
        logic [8:0]  rec_index;
        logic [3:0]  main_count;
        logic [3:0]  soft_count;
    } t_item;
endpackage
`default_nettype wire

// File: sv/nss_ram.sv
// ----------------------------------------------------------------------------
// nss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module nss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: sv/nss_front.sv
// ----------------------------------------------------------------------------
// nss_front
// Accepts items, drops ignored ones and queues the rest for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module nss_front #(
    parameter int MAX_ZONES    = nss_pkg::MAX_ZONES,
    parameter int MAX_VARIANTS = nss_pkg::MAX_VARIANTS,
    parameter int MAX_RECORDS  = nss_pkg::MAX_RECORDS
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire nss_pkg::t_item i_item,
    output logic                o_full,
    output logic                o_empty,
    input  wire logic           i_pop,
    output nss_pkg::t_item      o_item
);
    // Two-entry queue.
    nss_pkg::t_item r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           keep;

    always_comb begin
        keep = 1'b0;
        unique case (i_item.mode)
            nss_pkg::MODE_HDR:  keep = 32'(i_item.zone_index) < MAX_ZONES;
            nss_pkg::MODE_REC:  keep = 32'(i_item.zone_index) < MAX_ZONES
                                    && 32'(i_item.slot) < MAX_VARIANTS
                                    && 32'(i_item.rec_index) < MAX_RECORDS;
            nss_pkg::MODE_PICK: keep = 1'b1;
            default:            keep = 1'b0;
        endcase
    end

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && keep) begin
                r_q[r_wp] <= i_item;
                r_wp      <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push && keep} - {1'b0, i_pop};
        end
    end
endmodule
`default_nettype wire

// File: sv/nss_back.sv
// ----------------------------------------------------------------------------
// nss_back
// Executes table writes and picks: serial zone scan, LCG, serial modulo.
// ----------------------------------------------------------------------------
`default_nettype none
module nss_back #(
    parameter int MAX_ZONES    = nss_pkg::MAX_ZONES,
    parameter int MAX_VARIANTS = nss_pkg::MAX_VARIANTS
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_empty,
    input  wire nss_pkg::t_item i_item,
    output logic                o_pop,
    input  wire logic [16:0]    i_thresh,
    input  wire logic [5:0]     i_zcount,
    input  wire logic           i_seed_we,
    input  wire logic [31:0]    i_seed,
    output logic                o_valid,
    output logic                o_found,
    output logic [8:0]          o_picked_record,
    output logic [4:0]          o_zone_chosen,
    output logic                o_used_soft
);
    localparam int ZW = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
    localparam int VW = (MAX_VARIANTS > 1) ? $clog2(MAX_VARIANTS) : 1;
    localparam int CW = $clog2(MAX_VARIANTS + 1);
    localparam int RW = ZW + VW;
    localparam int LW = ZW + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_LAYER, S_MOD, S_READ, S_OUT
    } t_state;

    t_state r_state;
    nss_pkg::t_item r_it;
    logic [ZW:0]   r_idx;
    logic [ZW-1:0] r_best;
    logic [9:0]    r_bestd;
    logic          r_any;
    logic [31:0]   r_rng;
    logic          r_soft;
    logic [CW-1:0] r_n;
    logic [23:0]   r_rem;
    logic [4:0]    r_bit;
    logic [VW-1:0] r_pick;
    logic [2*MAX_ZONES-1:0]  r_lv;
    logic [23:0]   r_dv;

    // Zone header table: pitch and counts.
    logic [8+2*CW:0] hdr_rd;
    logic [8+2*CW:0] hdr_wd;
    logic [ZW-1:0]   hdr_ra;
    logic [CW-1:0]   mc_w, sc_w;
    assign mc_w = (32'(r_it.main_count) > MAX_VARIANTS) ? CW'(MAX_VARIANTS)
                                                        : CW'(r_it.main_count);
    assign sc_w = (32'(r_it.soft_count) > MAX_VARIANTS) ? CW'(MAX_VARIANTS)
                                                        : CW'(r_it.soft_count);
    assign hdr_wd = {r_it.note, mc_w, sc_w};
    assign hdr_ra = (r_state == S_SCAN) ? r_idx[ZW-1:0] : r_best;

    logic rec_we;
    logic r_wr_hdr, r_wr_rec;

    nss_ram #(.WIDTH(9 + 2*CW), .DEPTH(2**ZW)) u_hdr (
        .i_clk, .i_we(r_wr_hdr), .i_waddr(r_it.zone_index[ZW-1:0]),
        .i_wdata(hdr_wd), .i_raddr(hdr_ra), .o_rdata(hdr_rd)
    );

    logic [RW:0] rec_wa, rec_ra;
    logic [8:0]  rec_rd;
    assign rec_wa = {r_it.layer, r_it.zone_index[ZW-1:0], r_it.slot[VW-1:0]};
    assign rec_ra = {r_soft, r_best, r_pick};
    assign rec_we = r_wr_rec;
    nss_ram #(.WIDTH(9), .DEPTH(2**(RW+1))) u_rec (
        .i_clk, .i_we(rec_we), .i_waddr(rec_wa), .i_wdata(r_it.rec_index),
        .i_raddr(rec_ra), .o_rdata(rec_rd)
    );

    // Scan datapath: the read for index r_idx-1 arrives now.
    logic [ZW:0] nz;
    logic signed [9:0] dd;
    logic [9:0] ad;
    assign nz = (32'(i_zcount) > MAX_ZONES) ? (ZW+1)'(MAX_ZONES) : (ZW+1)'(i_zcount);
    assign dd = $signed({hdr_rd[8+2*CW], hdr_rd[8+2*CW:2*CW]})
              - $signed({r_it.note[8], r_it.note});
    assign ad = dd[9] ? 10'(-dd) : 10'(dd);

    logic [CW-1:0] hm, hs;
    assign hm = hdr_rd[2*CW-1:CW];
    assign hs = hdr_rd[CW-1:0];
    logic [31:0] rng_n;
    assign rng_n = r_rng * nss_pkg::LCG_MUL + nss_pkg::LCG_ADD;

    // Last pick per zone and layer. The address is stable for the whole
    // remainder loop, so the read data is ready when the loop ends.
    logic [LW-1:0] lpi;
    logic [VW-1:0] lp_rd, pick_nx;
    logic          lp_we, wrap;
    assign lpi     = {r_best, r_soft};
    assign lp_we   = r_state == S_MOD && r_bit == 5'd0;
    assign wrap    = ({1'b0, r_rem[CW-1:0]} + 1'b1) == {1'b0, r_n};
    assign pick_nx = (r_lv[lpi] && r_rem[VW-1:0] == lp_rd)
                   ? (wrap ? '0 : VW'(r_rem[VW-1:0] + 1'b1)) : r_rem[VW-1:0];
    nss_ram #(.WIDTH(VW), .DEPTH(2**LW)) u_lp (
        .i_clk, .i_we(lp_we), .i_waddr(lpi), .i_wdata(pick_nx),
        .i_raddr(lpi), .o_rdata(lp_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_lv     <= '0;
            r_rng    <= 32'd1;
            o_valid  <= 1'b0;
            o_pop    <= 1'b0;
            r_wr_hdr <= 1'b0;
            r_wr_rec <= 1'b0;
        end else begin
            o_valid  <= 1'b0;
            o_pop    <= 1'b0;
            r_wr_hdr <= 1'b0;
            r_wr_rec <= 1'b0;
            if (i_seed_we) begin
                r_rng <= i_seed;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty && !o_pop && !r_wr_hdr && !r_wr_rec) begin
                        o_pop <= 1'b1;
                        r_it  <= i_item;
                        if (i_item.mode == nss_pkg::MODE_HDR) begin
                            r_wr_hdr <= 1'b1;
                        end else if (i_item.mode == nss_pkg::MODE_REC) begin
                            r_wr_rec <= 1'b1;
                        end else begin
                            r_idx   <= '0;
                            r_any   <= 1'b0;
                            r_best  <= '0;
                            r_bestd <= 10'h3FF;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_idx != '0 && ad < r_bestd) begin
                        r_bestd <= ad;
                        r_best  <= ZW'(r_idx - 1'b1);
                        r_any   <= 1'b1;
                    end
                    if (r_idx == nz) begin
                        r_state <= S_LAYER;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_LAYER: begin
                    // hdr_rd holds r_best's header once r_idx is all ones; until then it waits.
                    if (!r_any) begin
                        o_found <= 1'b0; o_picked_record <= '0;
                        o_zone_chosen <= '0; o_used_soft <= 1'b0;
                        o_valid <= 1'b1; r_state <= S_IDLE;
                    end else if (hdr_ra == r_best && r_idx != '1) begin
                        r_idx <= '1;
                    end else begin
                        r_soft <= (r_it.velocity < i_thresh && hs != '0)
                               || (hm == '0 && hs != '0);
                        r_n    <= ((r_it.velocity < i_thresh && hs != '0)
                               || (hm == '0 && hs != '0)) ? hs : hm;
                        r_pick <= '0;
                        if (hm == '0 && hs == '0) begin
                            o_found <= 1'b0; o_picked_record <= '0;
                            o_zone_chosen <= 5'(r_best); o_used_soft <= 1'b0;
                            o_valid <= 1'b1; r_state <= S_IDLE;
                        end else if ((((r_it.velocity < i_thresh && hs != '0)
                               || (hm == '0 && hs != '0)) ? hs : hm) == CW'(1)) begin
                            r_state <= S_READ; r_bit <= '0;
                        end else begin
                            r_rng   <= rng_n;
                            r_rem   <= 24'd0;
                            r_dv    <= rng_n[31:8];
                            r_bit   <= 5'd24;
                            r_state <= S_MOD;
                        end
                    end
                end
                S_MOD: begin
                    // Restoring remainder, one bit a cycle.
                    if (r_bit != 5'd0) begin
                        if ({r_rem[22:0], r_dv[23]} >= 24'(r_n)) begin
                            r_rem <= {r_rem[22:0], r_dv[23]} - 24'(r_n);
                        end else begin
                            r_rem <= {r_rem[22:0], r_dv[23]};
                        end
                        r_dv  <= {r_dv[22:0], 1'b0};
                        r_bit <= r_bit - 1'b1;
                    end else begin
                        r_pick    <= pick_nx;
                        r_lv[lpi] <= 1'b1;
                        r_state   <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    o_found <= 1'b1; o_picked_record <= rec_rd;
                    o_zone_chosen <= 5'(r_best); o_used_soft <= r_soft;
                    o_valid <= 1'b1; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: sv/note_sample_selector.sv
// ----------------------------------------------------------------------------
// note_sample_selector
// Picks the recorded sample variant that plays for a note event.
// ----------------------------------------------------------------------------
// Usage: an item is taken when i_start is high and o_busy is low. Modes 0 and 1
// write the zone table; mode 2 asks for a pick and yields one result, shown
// for a single cycle with o_done high. Results cannot be held off.
// A two-entry queue sits between the front end, which accepts and filters
// items, and the back end, which runs them; o_busy is high while both queue
// entries are taken. The back end pops a table write and then writes it to
// its table, taking no new item until the write is done. A pick scans the
// zones serially, one header read a cycle, then, unless the chosen layer has
// a single variant, runs the LCG and a bit-serial 24-step remainder. A pick
// with no zone or an empty layer yields a result with o_found low. Each pick
// runs to its result before the back end takes the next queued item.
// Configuration registers are written through i_cfg_we/i_cfg_addr/i_cfg_data;
// the user must do so only while the block is idle, which the block does not
// enforce. A seed write also loads the generator. Reset empties the queue,
// clears the last-pick valid bits and zone count; threshold resets to 32768.
// ----------------------------------------------------------------------------
`default_nettype none
module note_sample_selector #(
    parameter int MAX_ZONES    = nss_pkg::MAX_ZONES,
    parameter int MAX_VARIANTS = nss_pkg::MAX_VARIANTS,
    parameter int MAX_RECORDS  = nss_pkg::MAX_RECORDS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [1:0]  i_mode,
    input  wire logic signed [8:0] i_note,
    input  wire logic [16:0] i_velocity,
    input  wire logic [4:0]  i_zone_index,
    input  wire logic        i_layer,
    input  wire logic [2:0]  i_slot,
    input  wire logic [8:0]  i_rec_index,
    input  wire logic [3:0]  i_main_count,
    input  wire logic [3:0]  i_soft_count,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [31:0] i_cfg_data,
    output logic             o_done,
    output logic             o_found,
    output logic [8:0]       o_picked_record,
    output logic [4:0]       o_zone_chosen,
    output logic             o_used_soft
);
    `include "assert_macros.svh"

    logic [16:0] r_thresh;
    logic [5:0]  r_zcount;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= 17'd32768;
            r_zcount <= 6'd0;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == nss_pkg::CFG_THRESH) r_thresh <= i_cfg_data[16:0];
            if (i_cfg_addr == nss_pkg::CFG_ZCOUNT) r_zcount <= i_cfg_data[5:0];
        end
    end

    nss_pkg::t_item item_in, item_q;
    assign item_in = '{mode: i_mode, note: i_note, velocity: i_velocity,
                       zone_index: i_zone_index, layer: i_layer, slot: i_slot,
                       rec_index: i_rec_index, main_count: i_main_count,
                       soft_count: i_soft_count};

    logic full, empty, pop;
    assign o_busy = full;

    nss_front #(.MAX_ZONES(MAX_ZONES), .MAX_VARIANTS(MAX_VARIANTS),
                .MAX_RECORDS(MAX_RECORDS)) u_front (
        .i_clk, .i_rst_n, .i_push(i_start && !full), .i_item(item_in),
        .o_full(full), .o_empty(empty), .i_pop(pop), .o_item(item_q)
    );

    nss_back #(.MAX_ZONES(MAX_ZONES), .MAX_VARIANTS(MAX_VARIANTS)) u_back (
        .i_clk, .i_rst_n, .i_empty(empty), .i_item(item_q), .o_pop(pop),
        .i_thresh(r_thresh), .i_zcount(r_zcount),
        .i_seed_we(i_cfg_we && i_cfg_addr == nss_pkg::CFG_SEED),
        .i_seed(i_cfg_data), .o_valid(o_done), .o_found(o_found),
        .o_picked_record(o_picked_record), .o_zone_chosen(o_zone_chosen),
        .o_used_soft(o_used_soft)
    );

    // A pop never happens on an empty queue.
    `ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, pop, !empty)
    // A result with no record carries no soft flag.
    `ASSERT_IMP(a_nofound_clean, i_clk, i_rst_n, o_done && !o_found,
                !o_used_soft && o_picked_record == 9'd0)
    // Results never come back to back.
    `ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done)
endmodule
`default_nettype wire
